// ===== src/rtt_trk_pkg.sv =====
// Package for the sender RTT/RTO sequence tracker.
// Holds the request and event codes, reset values and the queue item type.
// No dependencies.
`default_nettype none

package rtt_trk_pkg;

   // Request type codes on req_type.
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_SEND     = 2'd1;
   localparam logic [1:0] OP_FEEDBACK = 2'd2;
   localparam logic [1:0] OP_NONE     = 2'd3;

   // Event codes on rsp_event_kind.
   localparam logic [2:0] EV_SENT       = 3'd0;
   localparam logic [2:0] EV_NORMAL_FB  = 3'd1;
   localparam logic [2:0] EV_RESET_FB   = 3'd2;
   localparam logic [2:0] EV_IGNORED_FB = 3'd3;
   localparam logic [2:0] EV_TIMEOUT    = 3'd4;
   localparam logic [2:0] EV_QUIET      = 3'd5;

   // Configuration register index of the RTT floor. The initial value registers
   // need no storage: reset restores them to their defaults before they load.
   localparam logic [1:0] CSR_RTT_FLOOR = 2'd0;

   // Reset values.
   localparam logic [23:0] RTT_FLOOR_RESET   = 24'd10000;
   localparam logic [23:0] INITIAL_RTT_US    = 24'd10000;
   localparam logic [23:0] INITIAL_RTO_US    = 24'd2000000;
   localparam logic [23:0] INITIAL_RTTVAR_US = 24'd0;

   // Division by 1000 through a reciprocal: exact for gaps below 2^26 us.
   localparam logic [26:0] RECIP_1000      = 27'd68719477;
   localparam logic [31:0] INTERVAL_SAT_US = 32'd65536000;
   localparam logic [15:0] INTERVAL_MAX_MS = 16'hFFFF;
   localparam logic [23:0] SAT24           = 24'hFFFFFF;

   // One classified request as it travels from the front end to the back end.
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] clock_us;
      logic [23:0] gap_us;
      logic [15:0] interval_ms;
      logic [1:0]  msg_seq;
      logic        arm;
      logic        fb_seq_bit;
      logic [7:0]  fb_msg_seq;
      logic        fb_reset_bit;
      logic [22:0] fb_latency_us;
   } item_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== src/rtt_trk_front.sv =====
// Front end of the tracker: accepts requests, keeps the microsecond clock,
// the last send time and the message counter, and builds queue items.
// Depends on rtt_trk_pkg.
`default_nettype none

module rtt_trk_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_type,
   input  wire logic [15:0]            req_elapsed_us,
   input  wire logic                   req_fb_seq_bit,
   input  wire logic [7:0]             req_fb_msg_seq,
   input  wire logic                   req_fb_reset_bit,
   input  wire logic [22:0]            req_fb_latency_us,
   input  wire rtt_trk_pkg::q_status_type q_status,
   output logic                        push,
   output rtt_trk_pkg::item_type       push_item
);
   import rtt_trk_pkg::*;

   logic [31:0] clock_ff, clock_in;
   logic [31:0] last_send_ff, last_send_in;
   logic [1:0]  msg_ctr_ff, msg_ctr_in;

   logic [31:0] gap32;
   logic [52:0] ms_prod;
   logic [15:0] interval_ms;
   logic        accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept;

   // Gap since the last send, and its value in milliseconds via the reciprocal.
   assign gap32   = clock_ff - last_send_ff;
   assign ms_prod = {27'b0, gap32[25:0]} * {26'b0, RECIP_1000};
   assign interval_ms = (gap32 >= INTERVAL_SAT_US) ? INTERVAL_MAX_MS : ms_prod[51:36];

   // Timekeeping and message numbering follow the request types alone.
   always_comb begin
      clock_in     = clock_ff;
      last_send_in = last_send_ff;
      msg_ctr_in   = msg_ctr_ff;
      if (accept) begin
         case (req_type)
            OP_TICK: begin
               clock_in = clock_ff + {16'b0, req_elapsed_us};
            end
            OP_SEND: begin
               last_send_in = clock_ff;
               msg_ctr_in   = (msg_ctr_ff >= 2'd2) ? 2'd0 : msg_ctr_ff + 2'd1;
            end
            default: begin
               clock_in = clock_ff;
            end
         endcase
      end
   end

   // Item handed to the queue.
   always_comb begin
      push_item.op            = req_type;
      push_item.clock_us      = clock_in;
      push_item.gap_us        = (gap32[31:24] != 8'd0) ? SAT24 : gap32[23:0];
      push_item.interval_ms   = interval_ms;
      push_item.msg_seq       = msg_ctr_ff;
      push_item.arm           = (msg_ctr_ff >= 2'd2);
      push_item.fb_seq_bit    = req_fb_seq_bit;
      push_item.fb_msg_seq    = req_fb_msg_seq;
      push_item.fb_reset_bit  = req_fb_reset_bit;
      push_item.fb_latency_us = req_fb_latency_us;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff     <= 32'd0;
         last_send_ff <= 32'd0;
         msg_ctr_ff   <= 2'd0;
      end else begin
         clock_ff     <= clock_in;
         last_send_ff <= last_send_in;
         msg_ctr_ff   <= msg_ctr_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/rtt_trk_queue.sv =====
// Short request queue between the front and back ends of the tracker.
// Depends on rtt_trk_pkg.
`default_nettype none

module rtt_trk_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire rtt_trk_pkg::item_type   push_item,
   input  wire logic                    pop,
   output rtt_trk_pkg::item_type        head_item,
   output rtt_trk_pkg::q_status_type    q_status
);
   import rtt_trk_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head_item      = slots_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/rtt_trk_back.sv =====
// Back end of the tracker: holds the RTT, variance, RTO, sequence bit and
// reset timer, carries out queued requests and drives the response register.
// Depends on rtt_trk_pkg.
`default_nettype none

module rtt_trk_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [23:0]               rtt_floor,
   input  wire rtt_trk_pkg::item_type     head_item,
   input  wire rtt_trk_pkg::q_status_type q_status,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [2:0]                     rsp_event_kind,
   output logic                           rsp_hdr_seq_bit,
   output logic [1:0]                     rsp_hdr_msg_seq,
   output logic [15:0]                    rsp_hdr_interval_ms,
   output logic [23:0]                    rsp_next_send_delay_us,
   output logic [23:0]                    rsp_rtt_now_us,
   output logic [23:0]                    rsp_rto_now_us
);
   import rtt_trk_pkg::*;

   typedef enum logic [2:0] {
      ST_EXEC = 3'b001,
      ST_VAR  = 3'b010,
      ST_RTO  = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   // Estimator state.
   logic [23:0] rtt_est_ff, rtt_est_in;
   logic [23:0] rtt_var_ff, rtt_var_in;
   logic [23:0] rto_est_ff, rto_est_in;
   logic        seq_flag_ff, seq_flag_in;
   logic        armed_ff, armed_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [7:0]  acked_ff, acked_in;

   // Values carried between the steps of an estimator update.
   logic [2:0]  pend_kind_ff, pend_kind_in;
   logic [23:0] sample_ff, sample_in;
   logic [23:0] rtt_step_ff, rtt_step_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  ev_kind_ff, ev_kind_in;
   logic        hdr_seq_ff, hdr_seq_in;
   logic [1:0]  hdr_msg_ff, hdr_msg_in;
   logic [15:0] hdr_int_ff, hdr_int_in;
   logic [23:0] delay_ff, delay_in;
   logic [23:0] rtt_now_ff, rtt_now_in;
   logic [23:0] rto_now_ff, rto_now_in;

   logic        out_free;
   logic        emit;
   logic [23:0] rtt_rd;
   logic [23:0] rto_rd;
   logic [31:0] since_deadline;
   logic        expire;
   logic        fb_match;
   logic        long_op;
   logic [24:0] feed;
   logic [23:0] feed_sat;
   logic [23:0] fb_sample;
   logic [25:0] smooth_sum;
   logic [23:0] rtt_clamped;
   logic [23:0] diff;
   logic [26:0] var_sum;
   logic [26:0] rto_sum;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Clamped RTT read, and the clamped RTO used when the timer expires.
   assign rtt_rd = (rtt_est_ff <= rtt_floor) ? rtt_floor : rtt_est_ff;
   assign rto_rd = (rto_est_ff <= rtt_floor) ? rtt_floor : rto_est_ff;

   // Timer expiry on the clock value after the tick, with wrap-around.
   assign since_deadline = head_item.clock_us - deadline_ff;
   assign expire   = armed_ff && !since_deadline[31];
   assign fb_match = (head_item.fb_seq_bit == seq_flag_ff);
   assign long_op  = ((head_item.op == OP_TICK) && expire) ||
                     ((head_item.op == OP_FEEDBACK) && fb_match);

   // Normal feedback sample and the smoothed RTT.
   assign feed       = {1'b0, rtt_rd} + {1'b0, head_item.fb_latency_us, 1'b0};
   assign feed_sat   = feed[24] ? SAT24 : feed[23:0];
   assign fb_sample  = (feed_sat > head_item.gap_us) ? feed_sat : head_item.gap_us;
   assign smooth_sum = {rtt_rd, 1'b0} + {2'b0, rtt_rd} + {2'b0, fb_sample};

   // Variance step: (7 * var + |rtt - sample|) >> 3.
   assign rtt_clamped = (rtt_step_ff <= rtt_floor) ? rtt_floor : rtt_step_ff;
   assign diff    = (rtt_clamped > sample_ff) ? rtt_clamped - sample_ff
                                              : sample_ff - rtt_clamped;
   assign var_sum = {rtt_var_ff, 3'b0} - {3'b0, rtt_var_ff} + {3'b0, diff};

   // RTO step: (rtt + var + 3 * rto) >> 2, saturated.
   assign rto_sum = {3'b0, rtt_est_ff} + {3'b0, rtt_var_ff} +
                    {2'b0, rto_est_ff, 1'b0} + {3'b0, rto_est_ff};

   always_comb begin
      state_in     = state_ff;
      rtt_est_in   = rtt_est_ff;
      rtt_var_in   = rtt_var_ff;
      rto_est_in   = rto_est_ff;
      seq_flag_in  = seq_flag_ff;
      armed_in     = armed_ff;
      deadline_in  = deadline_ff;
      acked_in     = acked_ff;
      pend_kind_in = pend_kind_ff;
      sample_in    = sample_ff;
      rtt_step_in  = rtt_step_ff;
      ev_kind_in   = ev_kind_ff;
      hdr_seq_in   = hdr_seq_ff;
      hdr_msg_in   = hdr_msg_ff;
      hdr_int_in   = hdr_int_ff;
      delay_in     = delay_ff;
      rtt_now_in   = rtt_now_ff;
      rto_now_in   = rto_now_ff;
      pop          = 1'b0;
      emit         = 1'b0;

      case (state_ff)
         // Take the head request: finish it at once or start an estimator update.
         ST_EXEC: begin
            if (!q_status.empty) begin
               if (long_op) begin
                  pop      = 1'b1;
                  state_in = ST_VAR;
                  if (head_item.op == OP_TICK) begin
                     pend_kind_in = EV_TIMEOUT;
                     armed_in     = 1'b0;
                     seq_flag_in  = !seq_flag_ff;
                     rtt_step_in  = rto_est_ff;
                     sample_in    = rto_rd;
                  end else if (!head_item.fb_reset_bit) begin
                     pend_kind_in = EV_NORMAL_FB;
                     acked_in     = head_item.fb_msg_seq;
                     rtt_step_in  = smooth_sum[25:2];
                     sample_in    = fb_sample;
                  end else begin
                     pend_kind_in = EV_RESET_FB;
                     acked_in     = head_item.fb_msg_seq;
                     armed_in     = 1'b0;
                     seq_flag_in  = !seq_flag_ff;
                     rtt_step_in  = head_item.gap_us;
                     sample_in    = head_item.gap_us;
                  end
               end else if (out_free) begin
                  pop        = 1'b1;
                  emit       = 1'b1;
                  rtt_est_in = rtt_rd;
                  ev_kind_in = EV_QUIET;
                  hdr_seq_in = 1'b0;
                  hdr_msg_in = 2'd0;
                  hdr_int_in = 16'd0;
                  delay_in   = 24'd0;
                  rtt_now_in = rtt_rd;
                  rto_now_in = rto_est_ff;
                  if (head_item.op == OP_SEND) begin
                     ev_kind_in = EV_SENT;
                     hdr_seq_in = seq_flag_ff;
                     hdr_msg_in = head_item.msg_seq;
                     hdr_int_in = head_item.interval_ms;
                     delay_in   = rto_est_ff;
                     if (head_item.arm) begin
                        armed_in    = 1'b1;
                        deadline_in = head_item.clock_us + {8'b0, rto_est_ff};
                     end
                  end else if (head_item.op == OP_FEEDBACK) begin
                     ev_kind_in = EV_IGNORED_FB;
                  end
               end
            end
         end
         // Store the clamped RTT and the new variance.
         ST_VAR: begin
            rtt_est_in = rtt_clamped;
            rtt_var_in = var_sum[26:3];
            state_in   = ST_RTO;
         end
         // New RTO; the result leaves once the response register is free.
         ST_RTO: begin
            if (out_free) begin
               emit       = 1'b1;
               rto_est_in = rto_sum[26] ? SAT24 : rto_sum[25:2];
               ev_kind_in = pend_kind_ff;
               hdr_seq_in = 1'b0;
               hdr_msg_in = 2'd0;
               hdr_int_in = 16'd0;
               delay_in   = 24'd0;
               rtt_now_in = rtt_est_ff;
               rto_now_in = rto_sum[26] ? SAT24 : rto_sum[25:2];
               state_in   = ST_EXEC;
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   // Control and estimator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EXEC;
         rsp_valid_ff <= 1'b0;
         rtt_est_ff   <= INITIAL_RTT_US;
         rtt_var_ff   <= INITIAL_RTTVAR_US;
         rto_est_ff   <= INITIAL_RTO_US;
         seq_flag_ff  <= 1'b0;
         armed_ff     <= 1'b0;
         deadline_ff  <= 32'd0;
         acked_ff     <= 8'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rtt_est_ff   <= rtt_est_in;
         rtt_var_ff   <= rtt_var_in;
         rto_est_ff   <= rto_est_in;
         seq_flag_ff  <= seq_flag_in;
         armed_ff     <= armed_in;
         deadline_ff  <= deadline_in;
         acked_ff     <= acked_in;
      end
   end

   // Step values and response payload need no reset.
   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      sample_ff    <= sample_in;
      rtt_step_ff  <= rtt_step_in;
      ev_kind_ff   <= ev_kind_in;
      hdr_seq_ff   <= hdr_seq_in;
      hdr_msg_ff   <= hdr_msg_in;
      hdr_int_ff   <= hdr_int_in;
      delay_ff     <= delay_in;
      rtt_now_ff   <= rtt_now_in;
      rto_now_ff   <= rto_now_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_event_kind         = ev_kind_ff;
   assign rsp_hdr_seq_bit        = hdr_seq_ff;
   assign rsp_hdr_msg_seq        = hdr_msg_ff;
   assign rsp_hdr_interval_ms    = hdr_int_ff;
   assign rsp_next_send_delay_us = delay_ff;
   assign rsp_rtt_now_us         = rtt_now_ff;
   assign rsp_rto_now_us         = rto_now_ff;

endmodule

`default_nettype wire

// ===== src/sender_rtt_rto_seq_tracker.sv =====
// Sender RTT/RTO and sequence tracker. Each request (tick, send or feedback)
// gives exactly one response, held in the response register. Ticks, sends
// and feedback with a stale sequence bit are carried out at one request per
// cycle while the response register is free; feedback that is taken and a
// reset timer expiry each hold the back end through its variance and RTO
// update steps. A queue of QUEUE_DEPTH requests lets the front keep
// accepting meanwhile, and a response register lets new requests enter while
// a response waits. Only the RTT floor register is stored; the initial value
// registers always hold their defaults at reset. Depends on rtt_trk_pkg and
// the front, queue and back modules.
`default_nettype none

module sender_rtt_rto_seq_tracker #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [15:0] req_elapsed_us,
   input  wire logic        req_fb_seq_bit,
   input  wire logic [7:0]  req_fb_msg_seq,
   input  wire logic        req_fb_reset_bit,
   input  wire logic [22:0] req_fb_latency_us,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_kind,
   output logic             rsp_hdr_seq_bit,
   output logic [1:0]       rsp_hdr_msg_seq,
   output logic [15:0]      rsp_hdr_interval_ms,
   output logic [23:0]      rsp_next_send_delay_us,
   output logic [23:0]      rsp_rtt_now_us,
   output logic [23:0]      rsp_rto_now_us,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);
   import rtt_trk_pkg::*;

   logic [23:0]  rtt_floor_ff, rtt_floor_in;
   logic         push;
   logic         pop;
   item_type     push_item;
   item_type     head_item;
   q_status_type q_status;

   // RTT floor register.
   always_comb begin
      rtt_floor_in = rtt_floor_ff;
      if (csr_we && (csr_index == CSR_RTT_FLOOR)) begin
         rtt_floor_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rtt_floor_ff <= RTT_FLOOR_RESET;
      end else begin
         rtt_floor_ff <= rtt_floor_in;
      end
   end

   rtt_trk_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_elapsed_us    (req_elapsed_us),
      .req_fb_seq_bit    (req_fb_seq_bit),
      .req_fb_msg_seq    (req_fb_msg_seq),
      .req_fb_reset_bit  (req_fb_reset_bit),
      .req_fb_latency_us (req_fb_latency_us),
      .q_status          (q_status),
      .push              (push),
      .push_item         (push_item)
   );

   rtt_trk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   rtt_trk_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .rtt_floor              (rtt_floor_ff),
      .head_item              (head_item),
      .q_status               (q_status),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_event_kind         (rsp_event_kind),
      .rsp_hdr_seq_bit        (rsp_hdr_seq_bit),
      .rsp_hdr_msg_seq        (rsp_hdr_msg_seq),
      .rsp_hdr_interval_ms    (rsp_hdr_interval_ms),
      .rsp_next_send_delay_us (rsp_next_send_delay_us),
      .rsp_rtt_now_us         (rsp_rtt_now_us),
      .rsp_rto_now_us         (rsp_rto_now_us)
   );

endmodule

`default_nettype wire

// ===== src/rtt_trk_checker.sv =====
// Port-level checks for the sender RTT/RTO tracker, and their binding.
// Depends on rtt_trk_pkg and sender_rtt_rto_seq_tracker.
`default_nettype none

module rtt_trk_sva (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_event_kind,
   input wire logic        rsp_hdr_seq_bit,
   input wire logic [1:0]  rsp_hdr_msg_seq,
   input wire logic [15:0] rsp_hdr_interval_ms,
   input wire logic [23:0] rsp_next_send_delay_us,
   input wire logic [23:0] rsp_rto_now_us
);
   import rtt_trk_pkg::*;

   // No response is offered straight after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_event_kind) && $stable(rsp_rto_now_us))
      else $error("stalled response changed");

   // Header fields are zero on every event but a send.
   a_hdr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind != EV_SENT) |->
         !rsp_hdr_seq_bit && (rsp_hdr_msg_seq == 2'd0) &&
         (rsp_hdr_interval_ms == 16'd0) && (rsp_next_send_delay_us == 24'd0))
      else $error("header fields set on a non-send event");

   // A send reports the current RTO as its next-send delay.
   a_send_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_SENT) |->
         rsp_next_send_delay_us == rsp_rto_now_us)
      else $error("send delay differs from RTO");

   // The message number counts modulo three.
   a_msg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hdr_msg_seq != 2'd3)
      else $error("message number out of range");

endmodule

bind sender_rtt_rto_seq_tracker rtt_trk_sva u_rtt_trk_sva (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_event_kind         (rsp_event_kind),
   .rsp_hdr_seq_bit        (rsp_hdr_seq_bit),
   .rsp_hdr_msg_seq        (rsp_hdr_msg_seq),
   .rsp_hdr_interval_ms    (rsp_hdr_interval_ms),
   .rsp_next_send_delay_us (rsp_next_send_delay_us),
   .rsp_rto_now_us         (rsp_rto_now_us)
);

`default_nettype wire
